>>> hdl/base64_stream_decoder_top_defines.svh
// Assertion macros shared by the base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define B64D_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define B64D_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/b64d_pkg.sv
// Types shared by the base64 stream decoder modules.
package b64d_pkg;

	// Character classes.
	typedef enum logic [1:0] {
		CLS_SEXTET = 2'd0,
		CLS_SKIP   = 2'd1,
		CLS_PAD    = 2'd2,
		CLS_BAD    = 2'd3
	} b64d_cls_t;

	// One input request.
	typedef struct packed {
		logic [7:0] char_code;
		logic       first_of_string;
		logic       last_of_string;
	} b64d_in_t;

	// One result request.
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       string_done;
		logic       length_ok;
		logic       bad_char;
	} b64d_out_t;

	// Classifier output.
	typedef struct packed {
		b64d_cls_t  cls;
		logic [5:0] sextet;
	} b64d_class_t;

	// Decoder state.
	typedef struct packed {
		logic [1:0] phase;
		logic [5:0] prev;
		logic       stopped;
	} b64d_state_t;

endpackage

>>> hdl/b64d_classify.sv
// Character classifier: maps an 8-bit code to a class and a sextet value.
module b64d_classify import b64d_pkg::*; (
	input  logic [7:0]  char_code,
	output b64d_class_t class_o
);

	logic [7:0] c;
	assign c = char_code;

	// Decode the alphabet; pad and all non-sextets give value zero.
	always_comb begin
		class_o.cls    = CLS_BAD;
		class_o.sextet = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			class_o.cls    = CLS_SEXTET;
			class_o.sextet = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			class_o.cls    = CLS_SEXTET;
			class_o.sextet = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			class_o.cls    = CLS_SEXTET;
			class_o.sextet = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			class_o.cls    = CLS_SEXTET;
			class_o.sextet = 6'h3E;
		end else if (c == 8'h2F) begin
			class_o.cls    = CLS_SEXTET;
			class_o.sextet = 6'h3F;
		end else if (c == 8'h3D) begin
			class_o.cls = CLS_PAD;
		end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20 || c == 8'h2D) begin
			class_o.cls = CLS_SKIP;
		end
	end

endmodule

>>> hdl/b64d_step.sv
// Quartet step: next decoder state and result for one classified character.
module b64d_step import b64d_pkg::*; (
	input  b64d_state_t state_q,
	input  b64d_in_t    item,
	input  b64d_class_t class_i,
	output b64d_state_t state_d,
	output b64d_out_t   result
);

	logic [1:0] ph;
	logic       st;
	logic [5:0] pv;
	logic [5:0] v;

	// Clear phase and stop flag at the start of a string.
	assign ph = item.first_of_string ? 2'd0 : state_q.phase;
	assign st = item.first_of_string ? 1'b0 : state_q.stopped;
	assign pv = state_q.prev;
	assign v  = class_i.sextet;

	// Advance the quartet and build the output byte.
	always_comb begin
		state_d.phase      = ph;
		state_d.prev       = pv;
		state_d.stopped    = st;
		result.byte_valid  = 1'b0;
		result.byte_value  = 8'd0;
		result.bad_char    = 1'b0;
		if (!st) begin
			case (class_i.cls)
				CLS_BAD: begin
					result.bad_char = 1'b1;
				end
				CLS_SKIP: begin
				end
				default: begin
					if (class_i.cls == CLS_PAD && ph[1]) begin
						// Late pad ends the string.
						state_d.phase   = 2'd0;
						state_d.stopped = 1'b1;
					end else begin
						unique case (ph)
							2'd0: begin
								state_d.phase = 2'd1;
							end
							2'd1: begin
								result.byte_valid = 1'b1;
								result.byte_value = {pv, v[5:4]};
								state_d.phase     = 2'd2;
							end
							2'd2: begin
								result.byte_valid = 1'b1;
								result.byte_value = {pv[3:0], v[5:2]};
								state_d.phase     = 2'd3;
							end
							default: begin
								result.byte_valid = 1'b1;
								result.byte_value = {pv[1:0], v};
								state_d.phase     = 2'd0;
							end
						endcase
						state_d.prev = v;
					end
				end
			endcase
		end
		result.string_done = item.last_of_string;
		result.length_ok   = item.last_of_string && (state_d.phase == 2'd0);
	end

endmodule

>>> hdl/base64_stream_decoder_top.sv
// Base64 stream decoder top level: input register, decode step, result register.
// An accepted request waits in the input register until the result register is free.
// Throughput: one character per cycle unless out_ready stalls the result register.
// If empty, the input register takes a request while the result waits on out_ready.
// Reset (arst_n low, asynchronous) empties both registers and clears phase,
// previous sextet and stop flag; no clearing pass is needed.
`include "base64_stream_decoder_top_defines.svh"

module base64_stream_decoder_top import b64d_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  b64d_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output b64d_out_t out_data
);

	logic        valid_s1;
	b64d_in_t    item_s1;
	logic        res_valid_s2;
	b64d_out_t   res_s2;
	b64d_state_t state_q;
	b64d_state_t state_d;
	b64d_class_t class_s1;
	b64d_out_t   result;
	logic        advance;

	// Move the held request into the result register when it is free.
	assign advance  = valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Hold the accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	b64d_classify u_classify (
		.char_code (item_s1.char_code),
		.class_o   (class_s1)
	);

	b64d_step u_step (
		.state_q (state_q),
		.item    (item_s1),
		.class_i (class_s1),
		.state_d (state_d),
		.result  (result)
	);

	// Update decoder state and result valid on advance; else clear result valid on out_ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q      <= state_d;
			res_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	// Checks on decode and pipeline behavior.
	`B64D_ASSERT_IMP(a_bad_no_byte, out_valid, !(out_data.bad_char && out_data.byte_valid), "bad character produced a byte")
	`B64D_ASSERT_IMP(a_len_needs_done, out_valid, (!out_data.length_ok || out_data.string_done), "length_ok without string_done")
	`B64D_ASSERT_IMP(a_stop_phase_zero, state_q.stopped, (state_q.phase == 2'd0), "stopped with nonzero phase")
	`B64D_ASSERT_NXT(a_advance_fills, advance, out_valid, "advanced request missing from output")

endmodule

>>> tb/base64_stream_decoder_checker.sv
// Result checker for the base64 stream decoder: predicts each result and compares it.
module base64_stream_decoder_checker
	import b64d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  b64d_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  b64d_out_t out_data,
	output int        mismatches,
	output int        results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// Decoder state as seen by the prediction.
	logic [1:0] quartet_pos;
	logic [5:0] last_sextet;
	logic       pad_seen;

	b64d_out_t  pending_results[$];

	// Map one character code to its class and sextet value.
	function automatic b64d_class_t classify_char(logic [7:0] c);
		b64d_class_t k;
		k.cls    = CLS_SEXTET;
		k.sextet = '0;
		if (c >= "A" && c <= "Z") begin
			k.sextet = 6'(c - "A");
		end else if (c >= "a" && c <= "z") begin
			k.sextet = 6'(c - "a" + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			k.sextet = 6'(c - "0" + 8'd52);
		end else if (c == "+") begin
			k.sextet = 6'h3E;
		end else if (c == "/") begin
			k.sextet = 6'h3F;
		end else if (c == "=") begin
			k.cls = CLS_PAD;
		end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20 || c == "-") begin
			k.cls = CLS_SKIP;
		end else begin
			k.cls = CLS_BAD;
		end
		return k;
	endfunction

	// Advance the predicted state by one request and return its result.
	function automatic b64d_out_t decode_char(b64d_in_t req);
		b64d_class_t k;
		b64d_out_t   r;
		r = '0;
		if (req.first_of_string) begin
			quartet_pos = 2'd0;
			pad_seen    = 1'b0;
		end
		if (!pad_seen) begin
			k = classify_char(req.char_code);
			if (k.cls == CLS_BAD) begin
				r.bad_char = 1'b1;
			end else if (k.cls == CLS_SKIP) begin
				// skip whitespace and dashes
			end else if (k.cls == CLS_PAD && quartet_pos >= 2'd2) begin
				quartet_pos = 2'd0;
				pad_seen    = 1'b1;
			end else begin
				case (quartet_pos)
					2'd0: begin
						quartet_pos = 2'd1;
					end
					2'd1: begin
						r.byte_valid = 1'b1;
						r.byte_value = {last_sextet, k.sextet[5:4]};
						quartet_pos  = 2'd2;
					end
					2'd2: begin
						r.byte_valid = 1'b1;
						r.byte_value = {last_sextet[3:0], k.sextet[5:2]};
						quartet_pos  = 2'd3;
					end
					default: begin
						r.byte_valid = 1'b1;
						r.byte_value = {last_sextet[1:0], k.sextet};
						quartet_pos  = 2'd0;
					end
				endcase
				last_sextet = k.sextet;
			end
		end
		r.string_done = req.last_of_string;
		r.length_ok   = req.last_of_string && quartet_pos == 2'd0;
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare accepted results, then predict for accepted requests.
	always @(posedge clk or negedge arst_n) begin
		b64d_out_t want;
		if (!arst_n) begin
			quartet_pos = 2'd0;
			last_sextet = 6'd0;
			pad_seen    = 1'b0;
			pending_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: 0x%0h", out_data);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
					check_field("byte_value", want.byte_value, out_data.byte_value);
					check_field("string_done", 8'(want.string_done), 8'(out_data.string_done));
					check_field("length_ok", 8'(want.length_ok), 8'(out_data.length_ok));
					check_field("bad_char", 8'(want.bad_char), 8'(out_data.bad_char));
				end
			end
			if (in_valid && in_ready) begin
				pending_results.push_back(decode_char(in_data));
			end
		end
		results_due = pending_results.size();
	end

endmodule

>>> tb/testbench.sv
// Testbench top for the base64 stream decoder: clock, reset, stimulus and verdict.
module testbench;
	import b64d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] char_q_t[$];

	localparam int RANDOM_ITEMS = 1400;
	localparam int LONG_HOLD    = 80;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	b64d_in_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	b64d_out_t out_data;

	int mismatches;
	int results_due;
	int send_idle_pct = 38;
	int recv_idle_pct = 64;
	int hold_requests = 0;
	int items_sent    = 0;

	always #5 clk = ~clk;

	base64_stream_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	base64_stream_decoder_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.results_due(results_due)
	);

	// Stop a hung run.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Drive out_ready: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		int holds_seen;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [7:0] sextet_char(logic [5:0] v);
		if (v < 6'd26) return 8'("A") + 8'(v);
		if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
		if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
		if (v == 6'd62) return 8'("+");
		return 8'("/");
	endfunction

	function automatic char_q_t text_bytes(string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// Offer one request, with a random gap before it, and hold it until taken.
	task automatic push(b64d_in_t req);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_chars(char_q_t q, bit mark_first, bit mark_last);
		b64d_in_t req;
		for (int i = 0; i < q.size(); i++) begin
			req.char_code       = q[i];
			req.first_of_string = mark_first && i == 0;
			req.last_of_string  = mark_last && i == q.size() - 1;
			push(req);
		end
	endtask

	// Build one random string: mostly well-formed base64 with some noise mixed in.
	task automatic send_random_string();
		char_q_t body;
		char_q_t q;
		int      quartets;
		int      pads;
		int      n;
		logic [7:0] skips[5];
		skips = '{8'h09, 8'h0A, 8'h0D, 8'h20, 8'h2D};
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) body.push_back(8'($urandom_range(255)));
		end else begin
			quartets = $urandom_range(1, 4);
			repeat (quartets * 4) body.push_back(sextet_char(6'($urandom_range(63))));
			pads = $urandom_range(0, 2);
			for (int i = 0; i < pads; i++) body[body.size() - 1 - i] = "=";
			// drop a tail so the string can end mid-quartet
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) void'(body.pop_back());
			end
			// add characters after the padding
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) body.push_back(sextet_char(6'($urandom_range(63))));
			end
		end
		foreach (body[i]) begin
			if ($urandom_range(11) == 0) q.push_back(skips[$urandom_range(4)]);
			if ($urandom_range(29) == 0) q.push_back(8'($urandom_range(255)));
			q.push_back(body[i]);
		end
		send_chars(q, $urandom_range(9) != 0, $urandom_range(19) != 0);
	endtask

	// Reset, directed cases, random strings through three idle settings, verdict.
	initial begin
		char_q_t bad_q;
		int      mode;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cover alphabet extremes, missing first mark, early and late pads
		send_chars(text_bytes("AZaz"), 1, 1);
		send_chars(text_bytes("09+/"), 0, 1);
		send_chars(text_bytes("==AA"), 1, 1);
		send_chars(text_bytes("QQ=A"), 1, 1);
		send_chars(text_bytes("\t\n\015 -"), 1, 1);
		bad_q = {8'h00, 8'hFF, 8'h21};
		send_chars(bad_q, 1, 0);
		bad_q = {8'h80};
		send_chars(bad_q, 1, 1);

		mode = 0;
		while (items_sent < RANDOM_ITEMS + 25) begin
			if (mode == 0 && items_sent >= 25 + RANDOM_ITEMS / 3) begin
				mode = 1;
				send_idle_pct <= 64;
				recv_idle_pct <= 38;
			end else if (mode == 1 && items_sent >= 25 + 2 * RANDOM_ITEMS / 3) begin
				mode = 2;
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
				hold_requests <= hold_requests + 1;
			end
			send_random_string();
		end
		in_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> base64_stream_decoder_top.f
+incdir+hdl
hdl/b64d_pkg.sv
hdl/b64d_classify.sv
hdl/b64d_step.sv
hdl/base64_stream_decoder_top.sv
tb/base64_stream_decoder_checker.sv
tb/testbench.sv
